// ----- rtl/core/mmbd_pkg.sv -----
// Shared types and constants for the mipmap 2x2 box downsampler.
// No dependencies; used by mmbd_line_buf and mipmap_box_downsampler.
`default_nettype none

package mmbd_pkg;

  localparam int unsigned ChanW         = 16;    // one color channel
  localparam int unsigned SumW          = 18;    // sum of up to four channels
  localparam int unsigned NumChan       = 3;
  localparam int unsigned CfgW          = 13;    // widest config register
  localparam int unsigned MaxWidthDflt  = 4096;
  localparam int unsigned MaxHeight     = 4096;
  localparam int unsigned RowW          = 12;    // holds 0 .. MaxHeight-1
  localparam int unsigned HeightW       = 13;    // holds 1 .. MaxHeight

  typedef enum logic {
    RegSourceWidth  = 1'b0,
    RegSourceHeight = 1'b1
  } cfg_reg_e;

  // How a result is formed from the stage-1 sum
  typedef enum logic [1:0] {
    AvgPass = 2'd0,  // 1x1 source: pixel through
    AvgPair = 2'd1,  // 1x2 or 2x1 pair
    AvgQuad = 2'd2   // 2x2 block, line store entry added
  } avg_mode_e;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             level_done;
  } pixel_out_t;

  typedef logic [SumW-1:0] chan_sum_t;
  // index 0 red, 1 green, 2 blue
  typedef chan_sum_t [NumChan-1:0] line_sum_t;

endpackage

`default_nettype wire

// ----- rtl/core/mmbd_line_buf.sv -----
// Line store for the box downsampler: horizontal pair sums of the last even row.
// Single port, registered read. Uses mmbd_pkg.
`default_nettype none

module mmbd_line_buf #(
  parameter int unsigned Depth = mmbd_pkg::MaxWidthDflt / 2,
  parameter int unsigned AddrW = 11
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire                       re_i,
  input  wire [AddrW-1:0]           addr_i,
  input  wire mmbd_pkg::line_sum_t  wdata_i,
  output mmbd_pkg::line_sum_t       rdata_o
);

  mmbd_pkg::line_sum_t mem_q [Depth];
  mmbd_pkg::line_sum_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/mipmap_box_downsampler.sv -----
// Mipmap level builder: 2x2 box average over a raster-order RGB stream.
// Depends on mmbd_pkg and mmbd_line_buf.
//
// Usage:
//   Program source_width (index 0) and source_height (index 1) on the cfg port
//   while idle; any such write restarts the image at pixel 0,0. Out-of-range
//   sizes are clamped (0 -> 1, width -> MAX_WIDTH, height -> 4096).
//   Source pixels enter on in_* (valid/ready) in raster order, one item per
//   cycle sustained while out_* is not stalled. Each odd column of an odd
//   row (or of the single row or column in the degenerate cases) emits one
//   destination pixel on out_*; level_done marks the last one of the level.
//   After the last source pixel the position wraps and the next item starts
//   a new image. Pipeline: the line store read and the stage 1 load share
//   the edge accepting a result's last source item; the output register
//   loads from stage 1 whenever the output is free or being read.
//   Throughput: one item per clock unless out_* stalls; the single line store
//   port serves either the write (even rows) or the read (odd rows) of an item.
//   Stalls: with out_ready_i low, one result waits in the output register and
//   one more in stage 1; items causing no result keep flowing until stage 1 is
//   occupied, then in_ready_o drops.
//   Reset: size 1x1 (pass-through), position 0,0. The line store is not cleared;
//   every entry is written on an even row before the odd row reads it.
`default_nettype none

module mipmap_box_downsampler #(
  parameter int unsigned MAX_WIDTH = mmbd_pkg::MaxWidthDflt
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire                           cfg_idx_i,
  input  wire [mmbd_pkg::CfgW-1:0]      cfg_data_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire mmbd_pkg::pixel_in_t      in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output mmbd_pkg::pixel_out_t          out_data_o
);

  localparam int unsigned ClogW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DimW  = (ClogW > mmbd_pkg::CfgW) ? ClogW : mmbd_pkg::CfgW;
  localparam int unsigned XW    = ($clog2(MAX_WIDTH) > 1) ? $clog2(MAX_WIDTH) : 2;
  localparam int unsigned AW    = XW - 1;
  localparam int unsigned Depth = MAX_WIDTH / 2;
  localparam int unsigned SumW  = mmbd_pkg::SumW;
  localparam int unsigned ChanW = mmbd_pkg::ChanW;
  localparam int unsigned RowW  = mmbd_pkg::RowW;
  localparam int unsigned HW    = mmbd_pkg::HeightW;
  localparam int unsigned NumC  = mmbd_pkg::NumChan;

  // clamped image size
  logic [DimW-1:0] width_q, width_d;
  logic [HW-1:0]   height_q, height_d;
  logic            restart;

  logic [XW-1:0]   col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [NumC-1:0][ChanW-1:0] pair_q, pair_d;

  logic [NumC-1:0][ChanW-1:0] px;
  mmbd_pkg::line_sum_t        hsum;
  mmbd_pkg::line_sum_t        rd_data;

  logic accept;
  logic s1_move;

  // stage 1: result being assembled (line store read in flight)
  logic                  s1_valid_q, s1_valid_d;
  mmbd_pkg::line_sum_t   s1_sum_q;
  mmbd_pkg::avg_mode_e   s1_mode_q;
  logic                  s1_done_q;

  mmbd_pkg::pixel_out_t  out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  // stage 0 decode
  logic [DimW-1:0] width_even, col_ext, col_inc;
  logic [HW-1:0]   height_even, row_ext, row_inc;
  logic            one_wide, one_tall, col_in, row_in, in_range, even_phase;
  logic            gives_result, lb_we, lb_re, done;
  mmbd_pkg::avg_mode_e mode;

  // ---------------- configuration ----------------
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      restart = 1'b1;
      unique case (mmbd_pkg::cfg_reg_e'(cfg_idx_i))
        mmbd_pkg::RegSourceWidth: begin
          if (cfg_data_i == '0) begin
            width_d = DimW'(1);
          end else if (DimW'(cfg_data_i) > DimW'(MAX_WIDTH)) begin
            width_d = DimW'(MAX_WIDTH);
          end else begin
            width_d = DimW'(cfg_data_i);
          end
        end
        mmbd_pkg::RegSourceHeight: begin
          if (cfg_data_i == '0) begin
            height_d = HW'(1);
          end else if (HW'(cfg_data_i) > HW'(mmbd_pkg::MaxHeight)) begin
            height_d = HW'(mmbd_pkg::MaxHeight);
          end else begin
            height_d = HW'(cfg_data_i);
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- stage 0 ----------------
  assign px[0] = in_data_i.red_in;
  assign px[1] = in_data_i.green_in;
  assign px[2] = in_data_i.blue_in;

  always_comb begin
    for (int c = 0; c < NumC; c++) begin
      hsum[c] = SumW'(pair_q[c]) + SumW'(px[c]);
    end
  end

  assign width_even  = {width_q[DimW-1:1], 1'b0};
  assign height_even = {height_q[HW-1:1], 1'b0};
  assign col_ext     = DimW'(col_q);
  assign row_ext     = HW'(row_q);
  assign col_inc     = col_ext + DimW'(1);
  assign row_inc     = row_ext + HW'(1);
  assign one_wide    = (width_q == DimW'(1));
  assign one_tall    = (height_q == HW'(1));
  assign col_in      = (col_ext < width_even);
  assign row_in      = (row_ext < height_even);

  always_comb begin
    in_range     = 1'b0;
    even_phase   = 1'b0;
    gives_result = 1'b0;
    lb_we        = 1'b0;
    lb_re        = 1'b0;
    done         = 1'b0;
    mode         = mmbd_pkg::AvgPair;
    priority if (one_wide && one_tall) begin
      gives_result = 1'b1;
      done         = 1'b1;
      mode         = mmbd_pkg::AvgPass;
    end else if (one_wide) begin
      in_range     = row_in;
      even_phase   = ~row_q[0];
      gives_result = row_in && row_q[0];
      done         = (row_inc == height_even);
    end else if (one_tall) begin
      in_range     = col_in;
      even_phase   = ~col_q[0];
      gives_result = col_in && col_q[0];
      done         = (col_inc == width_even);
    end else begin
      in_range     = col_in && row_in;
      even_phase   = ~col_q[0];
      lb_we        = in_range && col_q[0] && ~row_q[0];
      lb_re        = in_range && col_q[0] && row_q[0];
      gives_result = lb_re;
      done         = (col_inc == width_even) && (row_inc == height_even);
      mode         = mmbd_pkg::AvgQuad;
    end
  end

  assign s1_move    = ~out_valid_q || out_ready_i;
  assign in_ready_o = ~s1_valid_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  // position and pending even pixel
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pair_d = pair_q;
    if (restart) begin
      col_d  = '0;
      row_d  = '0;
      pair_d = '0;
    end else if (accept) begin
      if (in_range && even_phase) begin
        pair_d = px;
      end
      if (col_inc >= width_q) begin
        col_d = '0;
        row_d = (row_inc >= height_q) ? '0 : row_inc[RowW-1:0];
      end else begin
        col_d = col_inc[XW-1:0];
      end
    end
  end

  mmbd_line_buf #(
    .Depth (Depth),
    .AddrW (AW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (accept && lb_we),
    .re_i    (accept && lb_re),
    .addr_i  (col_q[XW-1:1]),
    .wdata_i (hsum),
    .rdata_o (rd_data)
  );

  // ---------------- stage 1 / output ----------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = gives_result;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    logic [SumW:0]  total [NumC];
    logic [ChanW-1:0] res [NumC];
    for (int c = 0; c < NumC; c++) begin
      total[c] = (SumW + 1)'(s1_sum_q[c]);
      if (s1_mode_q == mmbd_pkg::AvgQuad) begin
        total[c] = total[c] + (SumW + 1)'(rd_data[c]);
      end
      unique case (s1_mode_q)
        mmbd_pkg::AvgPass: res[c] = total[c][ChanW-1:0];
        mmbd_pkg::AvgPair: res[c] = total[c][ChanW:1];
        mmbd_pkg::AvgQuad: res[c] = total[c][ChanW+1:2];
        default:           res[c] = total[c][ChanW-1:0];
      endcase
    end
    out_d = out_q;
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = s1_valid_q;
      if (s1_valid_q) begin
        out_d.red_out    = res[0];
        out_d.green_out  = res[1];
        out_d.blue_out   = res[2];
        out_d.level_done = s1_done_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= DimW'(1);
      height_q    <= HW'(1);
      col_q       <= '0;
      row_q       <= '0;
      pair_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pair_q      <= pair_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sum_q  <= (mode == mmbd_pkg::AvgPass) ?
                   {SumW'(px[2]), SumW'(px[1]), SumW'(px[0])} : hsum;
      s1_mode_q <= mode;
      s1_done_q <= done;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  a_ready_when_s1_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with stage 1 empty");

  a_col_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    DimW'(col_q) < width_q)
    else $error("column position beyond source width");

  a_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    HW'(row_q) < height_q)
    else $error("row position beyond source height");

  a_s1_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(s1_sum_q))
    else $error("stage 1 result lost while output stalled");

endmodule

`default_nettype wire
